// ===== src/teq_pkg.sv =====
package teq_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SlotsDef    = 16;
  localparam int unsigned TimeBitsDef = 32;

  // Fixed field widths of the stream beats
  localparam int unsigned ModeW   = 2;
  localparam int unsigned FieldTW = 32;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned StatusW = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_NOSLOT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_APPLY,
    S_DONE
  } state_e;

endpackage

// ===== src/teq_ram.sv =====
module teq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== src/timer_event_queue.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: mode; tdata: now, slot, expiry, immediate
// m_axis    out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: new_slot, fired, ...
//
// A beat runs through a scan of the expiry and last-run memories, one slot per cycle,
// then the S_LAST, S_APPLY and S_DONE states before its result is loaded.
// Reset clears the valid bits and the control state at once; memory contents stay
// undefined until an insert writes them, and no clearing pass is run.
// A result waits in the output register while the next beat is accepted and scanned;
// the sequencer holds in its final state only if that register is still full and m_axis_tready is low.
module timer_event_queue
  import teq_pkg::*;
#(
  parameter int unsigned SLOTS     = SlotsDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // now[31:0], slot[35:32], expiry[67:36], immediate[68]
  input  logic [1:0]  s_axis_tuser,   // mode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // new_slot[3:0], fired[4], fired_slot[8:5],
                                      // has_next[9], next_wakeup[41:10]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IdxW-1:0]      idx_t;

  // Full ordering key: expiry, then last run, then slot
  function automatic logic key_less(input time_t ea, input time_t la, input idx_t ia,
                                    input time_t eb, input time_t lb, input idx_t ib);
    logic res;
    res = (ea < eb) || ((ea == eb) && ((la < lb) || ((la == lb) && (ia < ib))));
    return res;
  endfunction

  state_e state_q, state_d;

  // Captured beat
  mode_e mode_q;
  time_t now_q, req_q;
  logic [SlotW-1:0] slot_q;
  logic imm_q;

  logic [SLOTS-1:0] valid_q, valid_d;

  // Scan pipeline
  idx_t rd_cnt_q, rd_cnt_d;
  logic cmp_vld_q;
  idx_t cmp_idx_q;
  time_t rd_exp, rd_lr;

  // Best and second-best valid entries, first free slot, addressed slot
  logic  best_vld_q, sec_vld_q, free_vld_q, cap_vld_q;
  time_t best_exp_q, best_lr_q, sec_exp_q, sec_lr_q, cap_lr_q;
  idx_t  best_idx_q, sec_idx_q, free_idx_q;

  // Staged result
  status_e res_status_q, res_status_d;
  idx_t    res_new_q, res_new_d, res_fired_idx_q, res_fired_idx_d;
  logic    res_fired_q, res_fired_d, res_has_q, res_has_d;
  time_t   res_wake_q, res_wake_d;

  // Output register
  logic             out_vld_q;
  status_e          out_status_q;
  logic [SlotW-1:0] out_new_q, out_fired_slot_q;
  logic             out_fired_q, out_has_q;
  logic [FieldTW-1:0] out_wake_q;

  logic in_acc, out_load;
  logic exp_we, lr_we;
  idx_t wr_addr, rd_addr;
  time_t wr_exp, wr_lr;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);
  assign rd_addr       = rd_cnt_q;

  teq_ram #(.DEPTH(SLOTS), .WIDTH(TIME_BITS)) u_exp_ram (
    .clk_i     (clk_i),
    .we_i      (exp_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_exp),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_exp)
  );

  teq_ram #(.DEPTH(SLOTS), .WIDTH(TIME_BITS)) u_lr_ram (
    .clk_i     (clk_i),
    .we_i      (lr_we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_lr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_lr)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_cnt_q  <= '0;
      cmp_vld_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      cmp_vld_q <= (state_q == S_SCAN);
      valid_q   <= valid_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        rd_cnt_d = '0;
        if (in_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_cnt_q == idx_t'(SLOTS - 1)) begin
          state_d = S_LAST;
        end else begin
          rd_cnt_d = rd_cnt_q + idx_t'(1);
        end
      end
      S_LAST:  state_d = S_APPLY;
      S_APPLY: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Capture the beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_e'(s_axis_tuser);
      now_q  <= time_t'(s_axis_tdata[31:0]);
      slot_q <= s_axis_tdata[35:32];
      req_q  <= time_t'(s_axis_tdata[67:36]);
      imm_q  <= s_axis_tdata[68];
    end
  end

  // Scan: keep the two best valid entries, the first free slot and the addressed slot
  logic cur_valid, beat_best, beat_sec;
  assign cur_valid = valid_q[cmp_idx_q];
  assign beat_best = !best_vld_q || key_less(rd_exp, rd_lr, cmp_idx_q,
                                             best_exp_q, best_lr_q, best_idx_q);
  assign beat_sec  = !sec_vld_q || key_less(rd_exp, rd_lr, cmp_idx_q,
                                            sec_exp_q, sec_lr_q, sec_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
      sec_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      cap_vld_q  <= 1'b0;
    end else if (in_acc) begin
      best_vld_q <= 1'b0;
      sec_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      cap_vld_q  <= 1'b0;
    end else if (cmp_vld_q) begin
      if (cur_valid) begin
        if (beat_best) begin
          best_vld_q <= 1'b1;
          sec_vld_q  <= best_vld_q;
        end else if (beat_sec) begin
          sec_vld_q <= 1'b1;
        end
        if (32'(cmp_idx_q) == 32'(slot_q)) begin
          cap_vld_q <= 1'b1;
        end
      end else if (!free_vld_q) begin
        free_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_cnt_q;
    if (cmp_vld_q) begin
      if (cur_valid) begin
        if (beat_best) begin
          best_exp_q <= rd_exp;
          best_lr_q  <= rd_lr;
          best_idx_q <= cmp_idx_q;
          sec_exp_q  <= best_exp_q;
          sec_lr_q   <= best_lr_q;
          sec_idx_q  <= best_idx_q;
        end else if (beat_sec) begin
          sec_exp_q <= rd_exp;
          sec_lr_q  <= rd_lr;
          sec_idx_q <= cmp_idx_q;
        end
        if (32'(cmp_idx_q) == 32'(slot_q)) begin
          cap_lr_q <= rd_lr;
        end
      end else if (!free_vld_q) begin
        free_idx_q <= cmp_idx_q;
      end
    end
  end

  // Apply the command and work out the root after it
  time_t req_eff, clamped;
  logic  fire, m_act, excl;
  time_t m_exp, m_lr;
  idx_t  m_idx, slot_idx;
  logic  oth_vld;
  time_t oth_exp;
  idx_t  oth_idx;
  time_t oth_lr;

  assign slot_idx = idx_t'(slot_q);
  assign req_eff  = (mode_q == MODE_INSERT && imm_q) ? '0 : req_q;
  assign clamped  = (now_q > req_eff) ? now_q : req_eff;
  assign fire     = best_vld_q && (now_q >= best_exp_q);

  always_comb begin
    m_act        = 1'b0;
    excl         = 1'b0;
    m_exp        = clamped;
    m_lr         = '0;
    m_idx        = slot_idx;
    exp_we       = 1'b0;
    lr_we        = 1'b0;
    valid_d      = valid_q;
    res_status_d = STATUS_OK;
    res_new_d    = '0;
    res_fired_d  = 1'b0;
    res_fired_idx_d = '0;
    case (mode_q)
      MODE_TICK: begin
        if (fire) begin
          m_act           = 1'b1;
          excl            = 1'b1;
          m_exp           = best_exp_q;
          m_lr            = now_q;
          m_idx           = best_idx_q;
          res_fired_d     = 1'b1;
          res_fired_idx_d = best_idx_q;
        end
      end
      MODE_INSERT: begin
        if (free_vld_q) begin
          m_act     = 1'b1;
          m_idx     = free_idx_q;
          res_new_d = free_idx_q;
        end else begin
          res_status_d = STATUS_FULL;
        end
      end
      MODE_REMOVE: begin
        if (cap_vld_q) begin
          excl = 1'b1;
        end else begin
          res_status_d = STATUS_NOSLOT;
        end
      end
      default: begin
        if (cap_vld_q) begin
          m_act = 1'b1;
          excl  = 1'b1;
          m_lr  = cap_lr_q;
        end else begin
          res_status_d = STATUS_NOSLOT;
        end
      end
    endcase

    if (state_q == S_APPLY) begin
      case (mode_q)
        MODE_TICK:   lr_we = fire;
        MODE_INSERT: begin
          exp_we = free_vld_q;
          lr_we  = free_vld_q;
          if (free_vld_q) begin
            valid_d[free_idx_q] = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (cap_vld_q) begin
            valid_d[slot_idx] = 1'b0;
          end
        end
        default: exp_we = cap_vld_q;
      endcase
    end
  end

  assign wr_addr = m_idx;
  assign wr_exp  = m_exp;
  assign wr_lr   = m_lr;

  // Best entry other than the one the command touched
  always_comb begin
    if (excl && best_vld_q && (best_idx_q == m_idx)) begin
      oth_vld = sec_vld_q;
      oth_exp = sec_exp_q;
      oth_lr  = sec_lr_q;
      oth_idx = sec_idx_q;
    end else begin
      oth_vld = best_vld_q;
      oth_exp = best_exp_q;
      oth_lr  = best_lr_q;
      oth_idx = best_idx_q;
    end
    if (m_act && (!oth_vld || key_less(m_exp, m_lr, m_idx, oth_exp, oth_lr, oth_idx))) begin
      res_has_d  = 1'b1;
      res_wake_d = m_exp;
    end else begin
      res_has_d  = oth_vld;
      res_wake_d = oth_vld ? oth_exp : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_APPLY) begin
      res_status_q    <= res_status_d;
      res_new_q       <= res_new_d;
      res_fired_q     <= res_fired_d;
      res_fired_idx_q <= res_fired_idx_d;
      res_has_q       <= res_has_d;
      res_wake_q      <= res_wake_d;
    end
  end

  // Output register: hold the result until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q     <= res_status_q;
      out_new_q        <= SlotW'(res_new_q);
      out_fired_q      <= res_fired_q;
      out_fired_slot_q <= SlotW'(res_fired_idx_q);
      out_has_q        <= res_has_q;
      out_wake_q       <= FieldTW'(res_wake_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {6'd0, out_wake_q, out_has_q, out_fired_slot_q, out_fired_q, out_new_q};

  // Checks
  a_ready_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmp_vld_q)
    else $error("scan data pending while a new beat can be accepted");

  a_write_in_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_we || lr_we) |-> (state_q == S_APPLY))
    else $error("memory written outside the apply step");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SCAN) && (rd_cnt_q == '0))
    else $error("accepted beat did not start a scan from slot zero");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_fired_q) |-> (out_status_q == STATUS_OK) && out_has_q)
    else $error("fired result with bad status or empty queue");

endmodule
